// ===== rtl/hvn_pkg.sv =====
// hvn_pkg: shared constants and the corner hash mix for the hashed value noise block.
// Depends on nothing; used by every module of the block except hvn_lerp.
package hvn_pkg;

   localparam int COORD_W = 32;
   localparam int SEED_W  = 32;
   localparam int OUT_W   = 27;
   localparam int OUT_MAX = 35717120;

   localparam int BYTE_LEVELS = 256;

   localparam logic [31:0] HASH_KX  = 32'd73856093;
   localparam logic [31:0] HASH_KY  = 32'd19349663;
   localparam logic [31:0] HASH_KZ  = 32'd83492791;
   localparam logic [31:0] HASH_MIX = 32'd1274126177;

   // avalanche step: (h ^ h>>13) * HASH_MIX, low 32 bits
   function automatic logic [31:0] mix_hash(input logic [31:0] h);
      logic [31:0] hs;
      hs = h ^ (h >> 13);
      return hs * HASH_MIX;
   endfunction

endpackage

// ===== rtl/hvn_axis.sv =====
// hvn_axis: one axis split into lattice index and smoothstep weight, five stages.
// Depends on hvn_pkg.
module hvn_axis #(
   parameter int FRAC_BITS    = 16,
   parameter int LATTICE_MASK = 255,
   parameter int IDX_W        = 8
) (
   input  logic                                clock,
   input  logic [4:0]                          stage_en,
   input  logic signed [hvn_pkg::COORD_W-1:0]  coord,
   output logic [IDX_W-1:0]                    idx,
   output logic [FRAC_BITS+2:0]                weight
);

   localparam int F     = FRAC_BITS;
   localparam int TW    = F + 3;
   localparam int SW    = F + 3;
   localparam int EXT_W = (F + IDX_W > hvn_pkg::COORD_W) ? F + IDX_W : hvn_pkg::COORD_W;
   localparam logic [TW-1:0]    THREE = TW'(3) << F;
   localparam logic [2*F:0]     HALF2 = (2*F+1)'(1) << (F - 1);
   localparam logic [2*F+3:0]   HALF4 = (2*F+4)'(1) << (F - 1);

   // stage 0: split, truncating toward zero
   logic                    neg;
   logic [F-1:0]            low;
   logic signed [EXT_W-1:0] vx;
   logic [EXT_W-1:0]        bias;
   logic [EXT_W-1:0]        sum;
   logic [IDX_W-1:0]        idx_in, idx_ff;
   logic signed [F:0]       f_in, f_ff;

   assign neg    = coord[hvn_pkg::COORD_W-1];
   assign low    = coord[F-1:0];
   assign vx     = EXT_W'(coord);
   assign bias   = {{(EXT_W-F){1'b0}}, {F{neg}}};
   assign sum    = vx + bias;
   assign idx_in = sum[F+IDX_W-1:F] & IDX_W'(LATTICE_MASK);
   assign f_in   = {neg & (|low), low};

   // stage 1: f*f and 3-2f
   logic signed [2*F+1:0] sq;
   logic [TW-1:0]         f_ext;
   logic [2*F-1:0]        ff_in, ff_ff;
   logic [TW-1:0]         t_in, t_ff;

   assign sq    = f_ff * f_ff;
   assign ff_in = sq[2*F-1:0];
   assign f_ext = TW'(f_ff);
   assign t_in  = THREE - {f_ext[TW-2:0], 1'b0};

   // stage 2: round f*f
   logic [2*F:0]  r2;
   logic [F:0]    f2_in, f2_ff;
   logic [TW-1:0] t2_ff;

   assign r2    = {1'b0, ff_ff} + HALF2;
   assign f2_in = r2[2*F:F];

   // stage 3: f2*(3-2f)
   logic [2*F+3:0] p_in, p_ff;

   assign p_in = (2*F+4)'(f2_ff) * (2*F+4)'(t2_ff);

   // stage 4: round to weight
   logic [2*F+3:0] r4;
   logic [SW-1:0]  s_in, s_ff;

   assign r4   = p_ff + HALF4;
   assign s_in = r4[F+SW-1:F];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         idx_ff <= idx_in;
         f_ff   <= f_in;
      end
      if (stage_en[1]) begin
         ff_ff <= ff_in;
         t_ff  <= t_in;
      end
      if (stage_en[2]) begin
         f2_ff <= f2_in;
         t2_ff <= t_ff;
      end
      if (stage_en[3]) begin
         p_ff <= p_in;
      end
      if (stage_en[4]) begin
         s_ff <= s_in;
      end
   end

   assign idx    = idx_ff;
   assign weight = s_ff;

endmodule

// ===== rtl/hvn_hash.sv =====
// hvn_hash: seeded hash of the eight lattice corners and byte-to-level lookup, four stages.
// Depends on hvn_pkg.
module hvn_hash #(
   parameter int FRAC_BITS = 16,
   parameter int IDX_W     = 8
) (
   input  logic                          clock,
   input  logic [3:0]                    stage_en,
   input  logic [IDX_W-1:0]              idx_x,
   input  logic [IDX_W-1:0]              idx_y,
   input  logic [IDX_W-1:0]              idx_z,
   input  logic [hvn_pkg::SEED_W-1:0]    seed,
   output logic [FRAC_BITS:0]            corner [8]
);

   localparam int CW = FRAC_BITS + 1;

   // level = round(byte * 2^F / 255), worked out at elaboration
   logic [CW-1:0] level_lut [hvn_pkg::BYTE_LEVELS];

   for (genvar g = 0; g < hvn_pkg::BYTE_LEVELS; g++) begin : g_lut
      assign level_lut[g] = CW'(((64'(g) << FRAC_BITS) + 64'd127) / 64'd255);
   end

   logic [31:0] ax [2];
   logic [31:0] ay [2];
   logic [31:0] az [2];

   assign ax[0] = 32'(idx_x);
   assign ax[1] = 32'((IDX_W+1)'(idx_x) + (IDX_W+1)'(1));
   assign ay[0] = 32'(idx_y);
   assign ay[1] = 32'((IDX_W+1)'(idx_y) + (IDX_W+1)'(1));
   assign az[0] = 32'(idx_z);
   assign az[1] = 32'((IDX_W+1)'(idx_z) + (IDX_W+1)'(1));

   logic [31:0]   hx_ff  [2];
   logic [31:0]   hy_ff  [2];
   logic [31:0]   hz_ff  [2];
   logic [31:0]   mix_ff [8];
   logic [CW-1:0] val_ff [8];
   logic [CW-1:0] out_ff [8];

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         if (stage_en[0]) begin
            hx_ff[i] <= ax[i] * hvn_pkg::HASH_KX;
            hy_ff[i] <= ay[i] * hvn_pkg::HASH_KY;
            hz_ff[i] <= az[i] * hvn_pkg::HASH_KZ;
         end
      end
      // corner n: bit 0 steps x, bit 1 steps y, bit 2 steps z
      for (int n = 0; n < 8; n++) begin
         if (stage_en[1]) begin
            mix_ff[n] <= hvn_pkg::mix_hash(seed ^ hx_ff[1'(n)] ^ hy_ff[1'(n >> 1)]
                                           ^ hz_ff[1'(n >> 2)]);
         end
         if (stage_en[2]) begin
            val_ff[n] <= level_lut[mix_ff[n][7:0] ^ mix_ff[n][23:16]];
         end
         if (stage_en[3]) begin
            out_ff[n] <= val_ff[n];
         end
      end
   end

   assign corner = out_ff;

endmodule

// ===== rtl/hvn_lerp.sv =====
// hvn_lerp: one blend lo + round(s*(hi-lo)), multiply stage then round-and-add stage.
// Depends on nothing outside this file.
module hvn_lerp #(
   parameter int FRAC_BITS = 16,
   parameter int SW        = 19,
   parameter int VW        = 18,
   parameter int OW        = 20
) (
   input  logic                 clock,
   input  logic                 en_mul,
   input  logic                 en_add,
   input  logic signed [VW-1:0] lo,
   input  logic signed [VW-1:0] hi,
   input  logic [SW-1:0]        weight,
   output logic signed [OW-1:0] result
);

   localparam int PW = SW + VW + 2;
   localparam logic signed [PW-1:0] HALF    = PW'(1) << (FRAC_BITS - 1);
   localparam logic signed [PW-1:0] HALF_M1 = HALF - PW'(1);

   logic signed [VW:0]   diff;
   logic signed [PW-1:0] prod_in, prod_ff;
   logic signed [VW-1:0] lo_ff;

   assign diff    = (VW+1)'(hi) - (VW+1)'(lo);
   assign prod_in = $signed({1'b0, weight}) * diff;

   // half away from zero: negative products take half-1 before the floor shift
   logic signed [PW-1:0] rnd;
   logic signed [OW-1:0] q;
   logic signed [OW-1:0] res_ff;

   assign rnd = prod_ff + (prod_ff[PW-1] ? HALF_M1 : HALF);
   assign q   = OW'($signed(rnd[PW-1:FRAC_BITS]));

   always_ff @(posedge clock) begin
      if (en_mul) begin
         prod_ff <= prod_in;
         lo_ff   <= lo;
      end
      if (en_add) begin
         res_ff <= OW'(lo_ff) + q;
      end
   end

   assign result = res_ff;

endmodule

// ===== rtl/hashed_value_noise_3d.sv =====
// An accepted req_ beat passes stages 0 to 11 in order; stage 11 is the output register.
// Throughput: one point per cycle while rsp_ready is high; twelve pipeline stages, each with
// its own valid bit. A stalled stage holds only while it is full, so bubbles close up and
// the block keeps taking beats while a result waits at the output register.
// Reset (synchronous, active high) empties the pipeline and clears the noise seed to 0.
module hashed_value_noise_3d #(
   parameter int FRAC_BITS    = 16,
   parameter int LATTICE_MASK = 255
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [hvn_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [hvn_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [hvn_pkg::COORD_W-1:0]  req_coord_z,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [hvn_pkg::OUT_W-1:0]    rsp_noise_value,
   input  logic                                csr_wr_en,
   input  logic [hvn_pkg::SEED_W-1:0]          csr_wr_data
);

   // Stage map:
   //   0      split coords: lattice index, signed fraction
   //   1..4   weight: f*f, round, *(3-2f), round   | hash: axis products, mix, lookup, hold
   //   5,6    blend along x (4 lanes)
   //   7,8    blend along y (2 lanes)
   //   9,10   blend along z
   //   11     saturate into the output register
   localparam int NSTAGE = 12;
   localparam int IDX_W  = $clog2(LATTICE_MASK + 1);
   localparam int F      = FRAC_BITS;
   localparam int SW     = F + 3;   // weight, unsigned, below 5.0
   localparam int CW     = F + 1;   // corner level, unsigned, 0..1
   localparam int V1     = F + 2;   // corner as signed
   localparam int O1     = F + 4;   // x blend result
   localparam int O2     = F + 7;   // y blend result
   localparam int O3     = F + 11;  // z blend result
   localparam int CMP_W  = (O3 > hvn_pkg::OUT_W) ? O3 : hvn_pkg::OUT_W;
   localparam logic signed [CMP_W-1:0] SAT_HI = CMP_W'(hvn_pkg::OUT_MAX);
   localparam logic signed [CMP_W-1:0] SAT_LO = -SAT_HI;

   // ---------------------------------------------------------------- seed register
   logic [hvn_pkg::SEED_W-1:0] noise_seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_seed_ff <= '0;
      end else if (csr_wr_en) begin
         noise_seed_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------- pipeline control
   // A stage loads when it is empty or when the stage after it loads.
   logic [NSTAGE-1:0] vld_ff;
   logic [NSTAGE-1:0] stage_en;

   always_comb begin
      stage_en[NSTAGE-1] = !vld_ff[NSTAGE-1] || rsp_ready;
      for (int k = NSTAGE - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= req_valid;
         end
         for (int k = 1; k < NSTAGE; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = vld_ff[NSTAGE-1];

   // ---------------------------------------------------------------- axis split and weights
   logic [IDX_W-1:0] idx_x, idx_y, idx_z;
   logic [SW-1:0]    wgt_u, wgt_v, wgt_w;

   hvn_axis #(.FRAC_BITS(F), .LATTICE_MASK(LATTICE_MASK), .IDX_W(IDX_W)) u_axis_x (
      .clock    (clock),
      .stage_en (stage_en[4:0]),
      .coord    (req_coord_x),
      .idx      (idx_x),
      .weight   (wgt_u)
   );

   hvn_axis #(.FRAC_BITS(F), .LATTICE_MASK(LATTICE_MASK), .IDX_W(IDX_W)) u_axis_y (
      .clock    (clock),
      .stage_en (stage_en[4:0]),
      .coord    (req_coord_y),
      .idx      (idx_y),
      .weight   (wgt_v)
   );

   hvn_axis #(.FRAC_BITS(F), .LATTICE_MASK(LATTICE_MASK), .IDX_W(IDX_W)) u_axis_z (
      .clock    (clock),
      .stage_en (stage_en[4:0]),
      .coord    (req_coord_z),
      .idx      (idx_z),
      .weight   (wgt_w)
   );

   // ---------------------------------------------------------------- corner hash
   logic [CW-1:0] corner [8];

   hvn_hash #(.FRAC_BITS(F), .IDX_W(IDX_W)) u_hash (
      .clock    (clock),
      .stage_en (stage_en[4:1]),
      .idx_x    (idx_x),
      .idx_y    (idx_y),
      .idx_z    (idx_z),
      .seed     (noise_seed_ff),
      .corner   (corner)
   );

   // ---------------------------------------------------------------- weight delay lines
   // v is needed at stage 7, w at stage 9; both leave the axis units at stage 4.
   logic [SW-1:0] wv_ff [2];
   logic [SW-1:0] ww_ff [4];

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         wv_ff[0] <= wgt_v;
         ww_ff[0] <= wgt_w;
      end
      if (stage_en[6]) begin
         wv_ff[1] <= wv_ff[0];
         ww_ff[1] <= ww_ff[0];
      end
      if (stage_en[7]) begin
         ww_ff[2] <= ww_ff[1];
      end
      if (stage_en[8]) begin
         ww_ff[3] <= ww_ff[2];
      end
   end

   // ---------------------------------------------------------------- trilinear blend
   logic signed [O1-1:0] blend_x [4];
   logic signed [O2-1:0] blend_y [2];
   logic signed [O3-1:0] blend_z;

   // x lanes: corners 2i and 2i+1 differ only in x
   for (genvar i = 0; i < 4; i++) begin : g_blend_x
      hvn_lerp #(.FRAC_BITS(F), .SW(SW), .VW(V1), .OW(O1)) u_lerp (
         .clock  (clock),
         .en_mul (stage_en[5]),
         .en_add (stage_en[6]),
         .lo     ($signed({1'b0, corner[2*i]})),
         .hi     ($signed({1'b0, corner[2*i+1]})),
         .weight (wgt_u),
         .result (blend_x[i])
      );
   end

   for (genvar j = 0; j < 2; j++) begin : g_blend_y
      hvn_lerp #(.FRAC_BITS(F), .SW(SW), .VW(O1), .OW(O2)) u_lerp (
         .clock  (clock),
         .en_mul (stage_en[7]),
         .en_add (stage_en[8]),
         .lo     (blend_x[2*j]),
         .hi     (blend_x[2*j+1]),
         .weight (wv_ff[1]),
         .result (blend_y[j])
      );
   end

   hvn_lerp #(.FRAC_BITS(F), .SW(SW), .VW(O2), .OW(O3)) u_lerp_z (
      .clock  (clock),
      .en_mul (stage_en[9]),
      .en_add (stage_en[10]),
      .lo     (blend_y[0]),
      .hi     (blend_y[1]),
      .weight (ww_ff[3]),
      .result (blend_z)
   );

   // ---------------------------------------------------------------- saturate, output register
   // Negative coords give weights above one, so the blend can overshoot; clamp symmetric.
   logic signed [CMP_W-1:0]          r_ext, r_sat;
   logic signed [hvn_pkg::OUT_W-1:0] noise_ff;

   assign r_ext = CMP_W'(blend_z);

   always_comb begin
      if (r_ext > SAT_HI) begin
         r_sat = SAT_HI;
      end else if (r_ext < SAT_LO) begin
         r_sat = SAT_LO;
      end else begin
         r_sat = r_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[NSTAGE-1]) begin
         noise_ff <= hvn_pkg::OUT_W'(r_sat);
      end
   end

   assign rsp_noise_value = noise_ff;

endmodule

// ===== verif/hvn_checker.sv =====
// hvn_checker: watches the req_, rsp_ and csr_ channels of hashed_value_noise_3d, predicts
// each noise value and compares it with the returned beat. Depends on hvn_pkg for widths.
`timescale 1ns / 100ps

module hvn_checker #(
   parameter int FRAC_BITS    = 16,
   parameter int LATTICE_MASK = 255
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [hvn_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [hvn_pkg::COORD_W-1:0]  req_coord_y,
   input  logic signed [hvn_pkg::COORD_W-1:0]  req_coord_z,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [hvn_pkg::OUT_W-1:0]    rsp_noise_value,
   input  logic                                csr_wr_en,
   input  logic [hvn_pkg::SEED_W-1:0]          csr_wr_data,
   output int                                  fail_count,
   output int                                  outstanding
);

   // lattice hash multipliers and final avalanche multiplier
   localparam logic [31:0] MUL_X     = 32'd73856093;
   localparam logic [31:0] MUL_Y     = 32'd19349663;
   localparam logic [31:0] MUL_Z     = 32'd83492791;
   localparam logic [31:0] AVALANCHE = 32'd1274126177;
   localparam longint      SAT_LIMIT = 35717120;

   typedef struct {
      logic [31:0] lattice_idx;
      longint      weight;
   } axis_split_type;

   logic [31:0]                       noise_seed = '0;
   logic signed [hvn_pkg::OUT_W-1:0]  noise_expected_q[$];
   int                                fails = 0;

   function automatic logic [31:0] lattice_hash(input logic [31:0] cx, input logic [31:0] cy,
                                                input logic [31:0] cz, input logic [31:0] s);
      logic [31:0] h;
      h = s ^ (cx * MUL_X) ^ (cy * MUL_Y) ^ (cz * MUL_Z);
      h = (h ^ (h >> 13)) * AVALANCHE;
      return h ^ (h >> 16);
   endfunction

   // drop FRAC_BITS, half rounded away from zero
   function automatic longint round_frac(input longint v);
      longint half;
      half = longint'(1) << (FRAC_BITS - 1);
      if (v >= 0) return (v + half) >>> FRAC_BITS;
      return -(((-v) + half) >>> FRAC_BITS);
   endfunction

   // truncate toward zero; fraction keeps the sign of the coordinate
   function automatic axis_split_type split_axis(input logic signed [31:0] raw);
      longint         v, mag, ip, f, f2, t;
      axis_split_type a;
      v   = longint'(raw);
      mag = (v < 0) ? -v : v;
      ip  = mag >>> FRAC_BITS;
      if (v < 0) ip = -ip;
      f = v - ip * (longint'(1) << FRAC_BITS);
      a.lattice_idx = 32'(ip) & 32'(LATTICE_MASK);
      f2 = round_frac(f * f);
      t  = (longint'(3) << FRAC_BITS) - 2 * f;
      a.weight = round_frac(f2 * t);
      return a;
   endfunction

   function automatic longint corner_level(input logic [31:0] cx, input logic [31:0] cy,
                                           input logic [31:0] cz, input logic [31:0] s);
      logic [31:0] h;
      logic [7:0]  b;
      h = lattice_hash(cx, cy, cz, s);
      b = h[7:0];
      return ((longint'(b) << FRAC_BITS) + 127) / 255;
   endfunction

   function automatic longint lerp(input longint a, input longint b, input longint s);
      return a + round_frac(s * (b - a));
   endfunction

   function automatic logic signed [hvn_pkg::OUT_W-1:0] predict_noise(
      input logic signed [31:0] x, input logic signed [31:0] y,
      input logic signed [31:0] z, input logic [31:0] s);
      axis_split_type ax, ay, az;
      logic [31:0]    x0, x1, y0, y1, z0, z1;
      longint         e00, e10, e01, e11, f0, f1, r;
      ax = split_axis(x);
      ay = split_axis(y);
      az = split_axis(z);
      x0 = ax.lattice_idx;  x1 = x0 + 1;   // no wrap of the upper corner
      y0 = ay.lattice_idx;  y1 = y0 + 1;
      z0 = az.lattice_idx;  z1 = z0 + 1;
      e00 = lerp(corner_level(x0, y0, z0, s), corner_level(x1, y0, z0, s), ax.weight);
      e10 = lerp(corner_level(x0, y1, z0, s), corner_level(x1, y1, z0, s), ax.weight);
      e01 = lerp(corner_level(x0, y0, z1, s), corner_level(x1, y0, z1, s), ax.weight);
      e11 = lerp(corner_level(x0, y1, z1, s), corner_level(x1, y1, z1, s), ax.weight);
      f0  = lerp(e00, e10, ay.weight);
      f1  = lerp(e01, e11, ay.weight);
      r   = lerp(f0, f1, az.weight);
      if (r > SAT_LIMIT)  r = SAT_LIMIT;
      if (r < -SAT_LIMIT) r = -SAT_LIMIT;
      return r[hvn_pkg::OUT_W-1:0];
   endfunction

   always @(posedge clock) begin : watch
      logic signed [hvn_pkg::OUT_W-1:0] want;
      if (reset) begin
         noise_seed = '0;
         noise_expected_q.delete();
      end else begin
         if (req_valid && req_ready)
            noise_expected_q.push_back(predict_noise(req_coord_x, req_coord_y, req_coord_z,
                                                     noise_seed));
         if (rsp_valid && rsp_ready) begin
            if (noise_expected_q.size() == 0) begin
               $display("%0t: rsp beat with no point pending, expected none, actual %0d",
                        $time, rsp_noise_value);
               fails++;
            end else begin
               want = noise_expected_q.pop_front();
               if (want !== rsp_noise_value) begin
                  $display("%0t: noise_value mismatch, expected %0d, actual %0d",
                           $time, want, rsp_noise_value);
                  fails++;
               end
            end
         end
         if (csr_wr_en) noise_seed = csr_wr_data;
      end
      fail_count  <= fails;
      outstanding <= noise_expected_q.size();
   end

endmodule

// ===== verif/hashed_value_noise_3d_tb.sv =====
// hashed_value_noise_3d_tb: drives points and seed writes into hashed_value_noise_3d and gives
// the verdict. Depends on hvn_pkg, the block itself and hvn_checker for prediction.
`timescale 1ns / 100ps

module hashed_value_noise_3d_tb;

   // Settle time after draining, a little longer than the pipe takes to empty.
   localparam int SETTLE_CYCLES = 16;
   // Generous limit for the slowest sane run, with the longest sender gaps and receiver stalls.
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_OFF_LEN  = 80;
   localparam int PHASE_POINTS  = 186;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_ready;
   logic signed [hvn_pkg::COORD_W-1:0]  req_coord_x = '0;
   logic signed [hvn_pkg::COORD_W-1:0]  req_coord_y = '0;
   logic signed [hvn_pkg::COORD_W-1:0]  req_coord_z = '0;
   logic                                rsp_valid;
   logic                                rsp_ready   = 1'b0;
   logic signed [hvn_pkg::OUT_W-1:0]    rsp_noise_value;
   logic                                csr_wr_en   = 1'b0;
   logic [hvn_pkg::SEED_W-1:0]          csr_wr_data = '0;

   int   fail_count;
   int   outstanding;
   int   cycle_count    = 0;
   logic steady         = 1'b0;   // last phase: no idling on either side
   logic hold_off_armed = 1'b0;   // asks the receiver for its one long stall

   hashed_value_noise_3d #(
      .FRAC_BITS    (16),
      .LATTICE_MASK (255)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   hvn_checker #(
      .FRAC_BITS    (16),
      .LATTICE_MASK (255)
   ) noise_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watchdog: a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Present one point and hold it until the beat is taken. Called at a rising edge;
   // returns at the edge where the beat was accepted.
   task automatic offer_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
      req_valid   <= 1'b1;
      req_coord_x <= x;
      req_coord_y <= y;
      req_coord_z <= z;
      do @(posedge clock); while (!req_ready);
   endtask

   // Random idle burst on the sending side; valid only drops when a gap really follows.
   task automatic sender_gap();
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   // Wait until every predicted noise value has come back, then let the pipe settle.
   // The first edge lets the count catch up with a beat taken at the current edge.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Seed writes only happen with the block empty.
   task automatic program_seed(input logic [31:0] s);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Coordinate mix: full-range noise, a band of small coordinates, near-integer and half-way
   // fractions (extreme and middle weights), and points by the top of the lattice index.
   function automatic logic [31:0] pick_coord();
      logic [15:0] int_part;
      logic [15:0] frac_part;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom();
         4, 5, 6:    return 32'(int'($urandom_range(0, 33554431)) - 16777216);
         7, 8: begin
            int_part = 16'(int'($urandom_range(0, 511)) - 256);
            case ($urandom_range(0, 4))
               0:       frac_part = 16'h0000;
               1:       frac_part = 16'h0001;
               2:       frac_part = 16'hFFFF;
               3:       frac_part = 16'h8000;
               default: frac_part = 16'h7FFF;
            endcase
            return {int_part, frac_part};
         end
         default: begin
            int_part = 16'(int'($urandom_range(0, 3)) + 253);
            return {int_part, 16'($urandom())};
         end
      endcase
   endfunction

   // Receiver: random stalls, one long hold-off while the sender keeps going so that the
   // pipe fills and req_ready drops, and a clean stretch at the end.
   initial begin : receiver
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_armed && !held) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_LEN) @(posedge clock);
         end else if (!steady && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 15)) @(posedge clock);
      end
   end

   initial begin : stimulus
      logic [31:0] seeds[5];
      logic [31:0] z;
      seeds[0] = 32'hFFFF_FFFF;
      seeds[1] = $urandom();
      seeds[2] = 32'h0000_0000;
      seeds[3] = 32'h8000_0001;
      seeds[4] = $urandom();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points under the reset seed.
      offer_point(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  sender_gap();
      offer_point(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);  sender_gap();
      offer_point(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);  sender_gap();
      offer_point(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);  sender_gap();
      // negative fractions: weights above one, result may leave [0,1]
      offer_point(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000);  sender_gap();
      offer_point(32'hFFFF_0001, 32'hFFFF_0001, 32'hFFFF_0001);  sender_gap();
      offer_point(32'hFFFF_0001, 32'h0000_FFFF, 32'hFFFF_0001);  sender_gap();
      offer_point(32'h8000_0001, 32'h7FFF_0001, 32'hFFFF_0001);  sender_gap();
      // field extremes
      offer_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);  sender_gap();
      offer_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);  sender_gap();
      offer_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  sender_gap();
      // index 255: upper corner at 256, not wrapped
      offer_point(32'h00FF_8000, 32'h00FF_8000, 32'h00FF_8000);  sender_gap();
      // negative integer parts: index from the two's complement low bits
      offer_point(32'hFF00_C000, 32'hFF01_0000, 32'hFFFF_0000);  sender_gap();
      // 2D use (z = 0), then alternating bit patterns
      offer_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0000);  sender_gap();
      offer_point(32'h0003_4000, 32'h0007_0000, 32'h0000_0000);  sender_gap();
      offer_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);  sender_gap();
      offer_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0);  sender_gap();

      // Random phases, one seed each; the final phase runs without idling.
      for (int p = 0; p < 5; p++) begin
         program_seed(seeds[p]);
         if (p == 1) hold_off_armed <= 1'b1;
         if (p == 4) steady <= 1'b1;
         for (int n = 0; n < PHASE_POINTS; n++) begin
            z = ($urandom_range(0, 9) == 0) ? 32'h0 : pick_coord();
            offer_point(pick_coord(), pick_coord(), z);
            sender_gap();
         end
      end

      drain();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/hvn_pkg.sv
rtl/hvn_axis.sv
rtl/hvn_hash.sv
rtl/hvn_lerp.sv
rtl/hashed_value_noise_3d.sv
verif/hvn_checker.sv
verif/hashed_value_noise_3d_tb.sv
